// ===== rtl/core/wmf_pkg.sv =====
`timescale 1ns / 1ps
package wmf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_WINDOW_DEF = 5;
  localparam int MAX_ROWS       = 1024;
  localparam int ROW_W          = 11;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int TAB_W          = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd3;

  localparam logic [1:0] MODE_ARITH  = 2'd0;
  localparam logic [1:0] MODE_GEO    = 2'd1;
  localparam logic [1:0] MODE_HARM   = 2'd2;
  localparam logic [1:0] MODE_CHARM  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAP,
    ST_TAIL,
    ST_DSTART,
    ST_DIV,
    ST_SRCH,
    ST_OUT
  } wmf_state_t;

  typedef struct packed {
    logic accept;
    logic tap_start;
    logic tap_step;
    logic div_start;
    logic div_step;
    logic srch_start;
    logic srch_step;
    logic out_load;
  } wmf_cmd_t;

  typedef struct packed {
    logic pix_ready;
    logic tap_last;
    logic div_done;
    logic srch_done;
    logic geo_search;
    logic out_busy;
  } wmf_stat_t;

  typedef logic [TAB_W-1:0] tab_t [256];

  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [31:0] isqrt_u64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bits;
    v    = v_in;
    res  = '0;
    bits = 64'h1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bits > v) bits = bits >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bits != 64'h0) begin
        if (v >= res + bits) begin
          v   = v - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
    end
    return res[31:0];
  endfunction

  // log2 in Q3.16: exact exponent, fraction by repeated squaring in Q1.30
  function automatic logic [TAB_W-1:0] log2_q16(input logic [7:0] x);
    logic [63:0] y;
    logic [3:0]  e;
    logic [15:0] frac;
    e    = '0;
    frac = '0;
    for (int k = 0; k < 7; k++) begin
      if ((x >> (k + 1)) != 8'h0) e = 4'(k + 1);
    end
    y = 64'(x) << (6'd30 - 6'(e));
    for (int i = 0; i < 16; i++) begin
      y    = (y * y) >> 30;
      frac = {frac[14:0], 1'b0};
      if (y >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        y       = y >> 1;
      end
    end
    return {e[2:0], frac};
  endfunction

  function automatic tab_t build_lg();
    tab_t t;
    t[0] = '0;
    for (int x = 1; x < 256; x++) t[x] = log2_q16(8'(x));
    return t;
  endfunction

  function automatic tab_t build_rc();
    tab_t t;
    t[0] = '0;
    for (int x = 1; x < 256; x++) t[x] = TAB_W'(div_u64(64'd65536, 64'(x)));
    return t;
  endfunction

  function automatic tab_t build_p05();
    tab_t t;
    t[0] = '0;
    for (int x = 1; x < 256; x++)
      t[x] = TAB_W'(isqrt_u64(div_u64(64'h1_0000_0000, 64'(x))));
    return t;
  endfunction

  function automatic tab_t build_p15();
    tab_t t;
    logic [63:0] cube;
    t[0] = '0;
    for (int x = 1; x < 256; x++) begin
      cube = 64'(x) * 64'(x) * 64'(x);
      t[x] = TAB_W'(isqrt_u64(div_u64(64'h1_0000_0000, cube)));
    end
    return t;
  endfunction

  localparam tab_t LG_TAB  = build_lg();
  localparam tab_t RC_TAB  = build_rc();
  localparam tab_t P05_TAB = build_p05();
  localparam tab_t P15_TAB = build_p15();

endpackage

// ===== rtl/core/wmf_if.sv =====
`timescale 1ns / 1ps
interface wmf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] sample;
  modport source (output valid, kind, sample, input ready);
  modport sink (input valid, kind, sample, output ready);
endinterface

interface wmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered;
  logic       frame_last;
  modport source (output valid, filtered, frame_last, input ready);
  modport sink (input valid, filtered, frame_last, output ready);
endinterface

// ===== rtl/core/window_mean_filter_unit.sv =====
`timescale 1ns / 1ps
// Square-window mean filter over an 8-bit image plane in raster order.
// in_if carries one word per sample (kind 0) or drain tick (kind 1); a word
// is taken when valid and ready are both high. out_if returns filtered
// pixels in raster order, frame_last marking the final pixel of a frame.
// cfg_we/cfg_index/cfg_data write window_size, mean_mode, image_height and
// image_width; any write restarts the frame. Write only while idle.
// Steps: a word that yields no pixel is only checked. A word that yields a
// pixel is followed by a walk over the n*n window (n = window side), a
// bit-serial divide of SUM_W quotient bits (SUM_W = 24 at the default 5x5
// maximum) and, in geometric mode, a binary search. The n*n window reads
// share the single read port of the line RAM. One word is in flight at a
// time; the next word is taken once the pixel sits in the output register.
// If the receiver stalls, the pixel holds in the output register; the unit
// takes words until the next pixel is ready and waits with it until the
// register frees. Reset restores register defaults (3x3, arithmetic,
// 1024x1024) and clears all position counters; the line RAM is not cleared.
module window_mean_filter_unit #(
  parameter int MAX_WIDTH  = wmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = wmf_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wmf_in_if.sink                         in_if,
  wmf_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wmf_pkg::*;

  wmf_cmd_t  cmd;
  wmf_stat_t stat;

  // sequencer: accept, window walk, divide, optional search, hand off
  wmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // configuration, counters, line RAM, accumulators, divider, search and output register
  wmf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_kind        (in_if.kind),
    .in_sample      (in_if.sample),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_filtered   (out_if.filtered),
    .out_frame_last (out_if.frame_last)
  );

endmodule

// ===== rtl/core/wmf_ram.sv =====
`timescale 1ns / 1ps
module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/wmf_ctrl.sv =====
`timescale 1ns / 1ps
module wmf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wmf_pkg::wmf_stat_t stat,
  output wmf_pkg::wmf_cmd_t  cmd
);
  import wmf_pkg::*;

  wmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = stat.pix_ready ? ST_TAP : ST_IDLE;
      ST_TAP:    if (stat.tap_last) state_nxt = ST_TAIL;
      ST_TAIL:   state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (stat.div_done) state_nxt = stat.geo_search ? ST_SRCH : ST_OUT;
      ST_SRCH:   if (stat.srch_done) state_nxt = ST_OUT;
      ST_OUT:    if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHECK:  cmd.tap_start = stat.pix_ready;
      ST_TAP:    cmd.tap_step = 1'b1;
      ST_TAIL:   ;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_DIV: begin
        cmd.div_step   = !stat.div_done;
        cmd.srch_start = stat.div_done && stat.geo_search;
      end
      ST_SRCH:   cmd.srch_step = !stat.srch_done;
      ST_OUT:    cmd.out_load = !stat.out_busy;
      default:   ;
    endcase
  end

endmodule

// ===== rtl/core/wmf_dp.sv =====
`timescale 1ns / 1ps
module wmf_dp #(
  parameter int MAX_WIDTH  = wmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = wmf_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_kind,
  input  logic [7:0]                      in_sample,
  input  wmf_pkg::wmf_cmd_t               cmd,
  output wmf_pkg::wmf_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_filtered,
  output logic                            out_frame_last
);
  import wmf_pkg::*;

  localparam int MAX_RAD = MAX_WINDOW / 2;
  localparam int RING    = 2 * MAX_RAD + 2;
  localparam int RING_W  = $clog2(RING);
  localparam int CW      = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH   = RING * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int TW      = $clog2(MAX_WINDOW);
  localparam int RADW    = $clog2(MAX_RAD + 1);
  localparam int NW      = $clog2(MAX_WINDOW + 1);
  localparam int AREA_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SUM_W   = TAB_W + AREA_W;
  localparam int DCW     = $clog2(SUM_W + 1);
  localparam int PW      = ((ROW_W > CW) ? ROW_W : CW) + 2;

  // configuration
  logic [2:0]       ws_r;
  logic [1:0]       mode_r;
  logic [ROW_W-1:0] ht_r, wd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= 3'd3;
      mode_r <= MODE_ARITH;
      ht_r   <= ROW_W'(MAX_ROWS);
      wd_r   <= ROW_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  ws_r   <= cfg_data[2:0];
        CFG_MEAN_MODE:    mode_r <= cfg_data[1:0];
        CFG_IMAGE_HEIGHT: ht_r   <= cfg_data;
        CFG_IMAGE_WIDTH:  wd_r   <= cfg_data;
        default:          ;
      endcase
    end
  end

  logic [RADW-1:0]   r_eff;
  logic [NW-1:0]     n_eff;
  logic [AREA_W-1:0] area;
  logic [ROW_W-1:0]  h_eff;
  logic [CW-1:0]     w_eff;

  always_comb begin
    if (int'(ws_r >> 1) > MAX_RAD) r_eff = RADW'(MAX_RAD);
    else                           r_eff = RADW'(ws_r >> 1);
    n_eff = NW'({r_eff, 1'b1});
    area  = AREA_W'(n_eff) * AREA_W'(n_eff);
    if (ht_r == '0)                  h_eff = ROW_W'(1);
    else if (int'(ht_r) > MAX_ROWS)  h_eff = ROW_W'(MAX_ROWS);
    else                             h_eff = ht_r;
    if (wd_r == '0)                  w_eff = CW'(1);
    else if (int'(wd_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else                             w_eff = CW'(wd_r);
  end

  // frame position counters
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0]     in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RING_W-1:0] in_ring_r, in_ring_nxt, out_ring_r, out_ring_nxt;
  logic              in_done_r, in_done_nxt;
  logic              wr_en, last_pix;

  assign wr_en    = cmd.accept && !in_kind && !in_done_r;
  assign last_pix = (out_row_r == h_eff - ROW_W'(1)) && (out_col_r == w_eff - CW'(1));

  always_comb begin
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_ring_nxt  = in_ring_r;
    in_done_nxt  = in_done_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_ring_nxt = out_ring_r;
    if (cfg_we || (cmd.out_load && last_pix)) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_ring_nxt  = '0;
      in_done_nxt  = 1'b0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_ring_nxt = '0;
    end else begin
      if (wr_en) begin
        if (in_col_r + CW'(1) >= w_eff) begin
          in_col_nxt  = '0;
          in_row_nxt  = in_row_r + ROW_W'(1);
          in_ring_nxt = (in_ring_r == RING_W'(RING - 1)) ? '0 : in_ring_r + RING_W'(1);
          if (in_row_r + ROW_W'(1) >= h_eff) in_done_nxt = 1'b1;
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end
      if (cmd.out_load) begin
        if (out_col_r + CW'(1) >= w_eff) begin
          out_col_nxt  = '0;
          out_row_nxt  = out_row_r + ROW_W'(1);
          out_ring_nxt = (out_ring_r == RING_W'(RING - 1)) ? '0 : out_ring_r + RING_W'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      in_done_r  <= 1'b0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_ring_r  <= in_ring_nxt;
      in_done_r  <= in_done_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_ring_r <= out_ring_nxt;
    end
  end

  // next output pixel is ready once its lowest right window sample is in
  logic [ROW_W-1:0] need_row;
  logic [CW-1:0]    need_col;

  always_comb begin
    need_row = out_row_r + ROW_W'(r_eff);
    if (need_row > h_eff - ROW_W'(1)) need_row = h_eff - ROW_W'(1);
    need_col = out_col_r + CW'(r_eff);
    if (need_col > w_eff - CW'(1)) need_col = w_eff - CW'(1);
  end

  assign stat.pix_ready = in_done_r || (in_row_r > need_row) ||
                          ((in_row_r == need_row) && (in_col_r > need_col));

  // window tap walk
  logic [TW-1:0] tap_a_r, tap_a_nxt, tap_b_r, tap_b_nxt;
  logic          tap_b_end;

  assign tap_b_end     = (tap_b_r == TW'(n_eff - NW'(1)));
  assign stat.tap_last = tap_b_end && (tap_a_r == TW'(n_eff - NW'(1)));

  always_comb begin
    tap_a_nxt = tap_a_r;
    tap_b_nxt = tap_b_r;
    if (cmd.tap_start) begin
      tap_a_nxt = '0;
      tap_b_nxt = '0;
    end else if (cmd.tap_step) begin
      if (tap_b_end) begin
        tap_b_nxt = '0;
        tap_a_nxt = tap_a_r + TW'(1);
      end else begin
        tap_b_nxt = tap_b_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    tap_a_r <= tap_a_nxt;
    tap_b_r <= tap_b_nxt;
  end

  // clamp the tap to the image and map its row onto the line ring
  logic signed [PW-1:0] row_s, col_s, dlt_s, ring_s;
  logic [AW-1:0]        rd_addr, wr_addr;

  always_comb begin
    row_s = $signed(PW'(out_row_r)) + $signed(PW'(tap_a_r)) - $signed(PW'(r_eff));
    if (row_s < 0)                                   row_s = '0;
    else if (row_s > $signed(PW'(h_eff)) - PW'(1))   row_s = $signed(PW'(h_eff)) - PW'(1);
    dlt_s  = row_s - $signed(PW'(out_row_r));
    ring_s = $signed(PW'(out_ring_r)) + dlt_s;
    if (ring_s < 0)                         ring_s = ring_s + PW'(RING);
    else if (ring_s >= $signed(PW'(RING)))  ring_s = ring_s - PW'(RING);
    col_s = $signed(PW'(out_col_r)) + $signed(PW'(tap_b_r)) - $signed(PW'(r_eff));
    if (col_s < 0)                                   col_s = '0;
    else if (col_s > $signed(PW'(w_eff)) - PW'(1))   col_s = $signed(PW'(w_eff)) - PW'(1);
    rd_addr = AW'(ring_s[RING_W-1:0]) * AW'(MAX_WIDTH) + AW'(col_s[CW-1:0]);
    wr_addr = AW'(in_ring_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
  end

  logic [7:0] tap_v;

  wmf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_sample),
    .raddr (rd_addr),
    .rdata (tap_v)
  );

  // accumulate taps in the cycle after each read
  logic             rd_pend_r;
  logic [SUM_W-1:0] s1_r, s2_r;
  logic             zero_r;
  logic [TAB_W-1:0] add1;

  always_comb begin
    unique case (mode_r)
      MODE_ARITH: add1 = TAB_W'(tap_v);
      MODE_GEO:   add1 = LG_TAB[tap_v];
      MODE_HARM:  add1 = RC_TAB[tap_v];
      MODE_CHARM: add1 = P05_TAB[tap_v];
      default:    add1 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else        rd_pend_r <= cmd.tap_step;
    if (cmd.tap_start) begin
      s1_r   <= '0;
      s2_r   <= '0;
      zero_r <= 1'b0;
    end else if (rd_pend_r) begin
      s1_r <= s1_r + SUM_W'(add1);
      s2_r <= s2_r + SUM_W'(P15_TAB[tap_v]);
      if (tap_v == 8'h0) zero_r <= 1'b1;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [SUM_W-1:0] div_num, div_den, qn_r, rem_r, den_r;
  logic [SUM_W:0]   rem_sh;
  logic [DCW-1:0]   div_left_r;

  always_comb begin
    unique case (mode_r)
      MODE_HARM: begin
        div_num = SUM_W'({area, 16'h0});
        div_den = s1_r;
      end
      MODE_CHARM: begin
        div_num = s1_r;
        div_den = s2_r;
      end
      default: begin
        div_num = s1_r;
        div_den = SUM_W'(area);
      end
    endcase
    rem_sh = {rem_r, qn_r[SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_left_r <= '0;
    end else if (cmd.div_start) begin
      div_left_r <= DCW'(SUM_W);
    end else if (cmd.div_step) begin
      div_left_r <= div_left_r - DCW'(1);
    end
    if (cmd.div_start) begin
      qn_r  <= div_num;
      rem_r <= '0;
      den_r <= div_den;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= SUM_W'(rem_sh - {1'b0, den_r});
        qn_r  <= {qn_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= SUM_W'(rem_sh);
        qn_r  <= {qn_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign stat.div_done   = (div_left_r == '0);
  assign stat.geo_search = (mode_r == MODE_GEO) && !zero_r;

  // geometric mean: binary search for the largest v with log2(v) <= mean log
  logic [7:0] srch_v_r, srch_c;
  logic [3:0] srch_left_r;
  logic [2:0] srch_bit;

  assign srch_bit = 3'(srch_left_r - 4'd1);
  assign srch_c   = srch_v_r | (8'h1 << srch_bit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_left_r <= '0;
    end else if (cmd.srch_start) begin
      srch_left_r <= 4'd8;
    end else if (cmd.srch_step) begin
      srch_left_r <= srch_left_r - 4'd1;
    end
    if (cmd.srch_start) begin
      srch_v_r <= '0;
    end else if (cmd.srch_step && (SUM_W'(LG_TAB[srch_c]) <= qn_r)) begin
      srch_v_r <= srch_c;
    end
  end

  assign stat.srch_done = (srch_left_r == '0);

  // result selection and output register
  logic [7:0] q_sat, px;

  assign q_sat = (qn_r > SUM_W'(255)) ? 8'hFF : qn_r[7:0];

  always_comb begin
    unique case (mode_r)
      MODE_ARITH: px = q_sat;
      MODE_GEO:   px = zero_r ? 8'h0 : srch_v_r;
      MODE_HARM:  px = (zero_r || (s1_r == '0)) ? 8'h0 : q_sat;
      MODE_CHARM: px = (zero_r || (s2_r == '0)) ? 8'h0 : q_sat;
      default:    px = 8'h0;
    endcase
  end

  logic       out_valid_r;
  logic [7:0] out_filt_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_filt_r <= px;
      out_last_r <= last_pix;
    end
  end

  assign stat.out_busy  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filt_r;
  assign out_frame_last = out_last_r;

endmodule
